// File: hdl/ir_pulse_width_code_decoder_assert.svh
// ----------------------------------------------------------------------------
// ir_pulse_width_code_decoder_assert.svh
// Assertion macros used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_CODE_DECODER_ASSERT_SVH
`define IR_PULSE_WIDTH_CODE_DECODER_ASSERT_SVH

// check a property outside of reset
`define IPWCD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipwcd assertion failed");

// check a property on every clock edge, reset included
`define IPWCD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("ipwcd assertion failed");

`endif

// File: hdl/ipwcd_pkg.sv
// ----------------------------------------------------------------------------
// ipwcd_pkg
// Shared widths, register indexes, reset values, result kinds and phase codes
// of the IR pulse-width code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipwcd_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_W-1:0]     t_cfg_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_SYNC_MIN      = 3'd0;
    localparam t_cfg_index REG_SYNC_MAX      = 3'd1;
    localparam t_cfg_index REG_PAUSE_MIN     = 3'd2;
    localparam t_cfg_index REG_PAUSE_MAX     = 3'd3;
    localparam t_cfg_index REG_ONE_THRESHOLD = 3'd4;
    localparam t_cfg_index REG_BURST_LIMIT   = 3'd5;
    localparam t_cfg_index REG_IDLE_GAP      = 3'd6;

    localparam t_cfg_word RST_SYNC_MIN      = 24'h001B80;
    localparam t_cfg_word RST_SYNC_MAX      = 24'h001D00;
    localparam t_cfg_word RST_PAUSE_MIN     = 24'h000600;
    localparam t_cfg_word RST_PAUSE_MAX     = 24'h000800;
    localparam t_cfg_word RST_ONE_THRESHOLD = 24'h000900;
    localparam t_cfg_word RST_BURST_LIMIT   = 24'h001000;
    localparam t_cfg_word RST_IDLE_GAP      = 24'd3000000;

    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] PH_HUNT_HIGH = 2'd0;
    localparam logic [1:0] PH_HUNT_LOW  = 2'd1;
    localparam logic [1:0] PH_PAUSE     = 2'd2;
    localparam logic [1:0] PH_BURST     = 2'd3;

endpackage

`default_nettype wire

// File: hdl/ir_pulse_width_code_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_code_decoder
// Pulse-width IR remote decoder: measures low bursts and high pauses of an
// active-low receiver line and assembles frames into codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one line sample per timer
//   tick on i_ir_level (1 idle high, 0 carrier). Every tick must be sent.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the seven timing
//   registers by index; o_cfg_ready is always high. Write only while idle.
//   Output channel (o_out_valid / i_out_ready) gives at most one word per
//   sample: a code with its index in the burst (o_kind 0), or the end of a
//   burst with the code count (o_kind 1).
//   Throughput: one sample per cycle. Latency: a result appears in the
//   cycle after the sample that causes it, out of a single output register.
//   A sample is taken while the output register is empty or being emptied
//   in the same cycle; a stalled receiver holds o_out_valid and the payload
//   and blocks further samples only while the register stays full.
//   Reset (synchronous, active low) restores the register defaults, drops
//   any pending result and starts hunting in idle high with counters clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_code_decoder #(
    parameter int CODE_BITS  = 15,
    parameter int MAX_CODES  = 64,
    parameter int COUNT_BITS = 24
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  ipwcd_pkg::t_cfg_index      i_cfg_index,
    input  wire  ipwcd_pkg::t_cfg_word       i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_ir_level,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_kind,
    output logic [CODE_BITS-1:0]             o_code_value,
    output logic [$clog2(MAX_CODES+1)-1:0]   o_position
);

    import ipwcd_pkg::*;

    localparam int POS_W = $clog2(MAX_CODES + 1);
    localparam int BIT_W = $clog2(CODE_BITS + 1);
    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    t_cfg_word r_sync_min, r_sync_max, r_pause_min, r_pause_max;
    t_cfg_word r_one_threshold, r_burst_limit, r_idle_gap;

    logic [1:0]            r_phase,       n_phase;
    logic [COUNT_BITS-1:0] r_tick_count,  n_tick_count;
    logic [CODE_BITS-1:0]  r_shift_code,  n_shift_code;
    logic [BIT_W-1:0]      r_bit_count,   n_bit_count;
    logic [POS_W-1:0]      r_codes,       n_codes;
    logic                  r_burst_active, n_burst_active;

    logic                  r_out_valid;
    logic                  r_kind,        n_kind;
    logic [CODE_BITS-1:0]  r_code_value,  n_code_value;
    logic [POS_W-1:0]      r_position,    n_position;
    logic                  n_emit;

    logic                  w_accept;
    logic                  w_level_high;
    logic [COUNT_BITS-1:0] w_tick_inc;
    logic [CMP_W-1:0]      w_len;
    logic [CMP_W-1:0]      w_inc;
    logic [CODE_BITS-1:0]  w_shifted;
    logic [BIT_W-1:0]      w_bits_inc;
    logic                  w_room;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign w_accept     = i_in_valid && o_in_ready;

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_code_value = r_code_value;
    assign o_position   = r_position;

    assign w_level_high = (r_phase == PH_HUNT_HIGH) || (r_phase == PH_PAUSE);
    assign w_tick_inc   = (r_tick_count == COUNT_MAX) ? r_tick_count
                                                      : r_tick_count + 1'b1;
    assign w_len        = CMP_W'(r_tick_count);
    assign w_inc        = CMP_W'(w_tick_inc);
    assign w_shifted    = (r_shift_code << 1)
                        | CODE_BITS'(w_len > CMP_W'(r_one_threshold));
    assign w_bits_inc   = r_bit_count + 1'b1;
    assign w_room       = (r_codes < POS_W'(MAX_CODES));

    always_comb begin
        n_phase        = r_phase;
        n_tick_count   = r_tick_count;
        n_shift_code   = r_shift_code;
        n_bit_count    = r_bit_count;
        n_codes        = r_codes;
        n_burst_active = r_burst_active;
        n_emit         = 1'b0;
        n_kind         = KIND_CODE;
        n_code_value   = r_shift_code;
        n_position     = r_codes;

        if (i_ir_level == w_level_high) begin
            n_tick_count = w_tick_inc;
            if ((r_phase == PH_HUNT_HIGH) && r_burst_active
                    && (w_inc > CMP_W'(r_idle_gap))) begin
                n_emit         = 1'b1;
                n_kind         = KIND_END;
                n_code_value   = '0;
                n_position     = r_codes;
                n_burst_active = 1'b0;
                n_codes        = '0;
            end
        end else begin
            n_tick_count = COUNT_BITS'(1);
            unique case (r_phase)
                PH_HUNT_HIGH: begin
                    n_phase = PH_HUNT_LOW;
                end
                PH_HUNT_LOW: begin
                    if ((w_len >= CMP_W'(r_sync_min)) && (w_len <= CMP_W'(r_sync_max))) begin
                        n_shift_code   = '0;
                        n_bit_count    = '0;
                        n_burst_active = 1'b1;
                        n_phase        = PH_PAUSE;
                    end else begin
                        n_phase = PH_HUNT_HIGH;
                    end
                end
                PH_PAUSE: begin
                    if ((w_len < CMP_W'(r_pause_min)) || (w_len > CMP_W'(r_pause_max))) begin
                        n_emit  = w_room;
                        n_phase = PH_HUNT_LOW;
                        if (w_room) begin
                            n_codes = r_codes + 1'b1;
                        end
                    end else begin
                        n_phase = PH_BURST;
                    end
                end
                default: begin
                    n_shift_code = w_shifted;
                    n_code_value = w_shifted;
                    n_bit_count  = w_bits_inc;
                    if ((w_len > CMP_W'(r_burst_limit))
                            || (w_bits_inc >= BIT_W'(CODE_BITS))) begin
                        n_emit  = w_room;
                        n_phase = PH_HUNT_HIGH;
                        if (w_room) begin
                            n_codes = r_codes + 1'b1;
                        end
                    end else begin
                        n_phase = PH_PAUSE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_min      <= RST_SYNC_MIN;
            r_sync_max      <= RST_SYNC_MAX;
            r_pause_min     <= RST_PAUSE_MIN;
            r_pause_max     <= RST_PAUSE_MAX;
            r_one_threshold <= RST_ONE_THRESHOLD;
            r_burst_limit   <= RST_BURST_LIMIT;
            r_idle_gap      <= RST_IDLE_GAP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SYNC_MIN:      r_sync_min      <= i_cfg_data;
                REG_SYNC_MAX:      r_sync_max      <= i_cfg_data;
                REG_PAUSE_MIN:     r_pause_min     <= i_cfg_data;
                REG_PAUSE_MAX:     r_pause_max     <= i_cfg_data;
                REG_ONE_THRESHOLD: r_one_threshold <= i_cfg_data;
                REG_BURST_LIMIT:   r_burst_limit   <= i_cfg_data;
                REG_IDLE_GAP:      r_idle_gap      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT_HIGH;
            r_tick_count   <= '0;
            r_shift_code   <= '0;
            r_bit_count    <= '0;
            r_codes        <= '0;
            r_burst_active <= 1'b0;
        end else if (w_accept) begin
            r_phase        <= n_phase;
            r_tick_count   <= n_tick_count;
            r_shift_code   <= n_shift_code;
            r_bit_count    <= n_bit_count;
            r_codes        <= n_codes;
            r_burst_active <= n_burst_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_kind       <= n_kind;
            r_code_value <= n_code_value;
            r_position   <= n_position;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ipwcd_checker.sv
// ----------------------------------------------------------------------------
// ipwcd_checker
// Port-level checks of the IR pulse-width code decoder, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_width_code_decoder_assert.svh"

module ipwcd_checker #(
    parameter int CODE_BITS = 15,
    parameter int MAX_CODES = 64
) (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_in_ready,
    input wire                            o_out_valid,
    input wire                            i_out_ready,
    input wire                            o_kind,
    input wire [CODE_BITS-1:0]            o_code_value,
    input wire [$clog2(MAX_CODES+1)-1:0]  o_position
);

    import ipwcd_pkg::*;

    localparam int POS_W = $clog2(MAX_CODES + 1);

    wire                       w_out_stall;
    wire                       w_out_end;
    wire                       w_out_code;
    wire [CODE_BITS+POS_W:0]   w_out_word;

    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_out_end   = o_out_valid && (o_kind == KIND_END);
    assign w_out_code  = o_out_valid && (o_kind == KIND_CODE);
    assign w_out_word  = {o_kind, o_code_value, o_position};

    // hold a stalled word
    `IPWCD_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> (o_out_valid && $stable(w_out_word)))

    `IPWCD_ASSERT(a_end_zero, i_clk, i_rst_n, w_out_end |-> (o_code_value == '0))

    `IPWCD_ASSERT(a_code_pos, i_clk, i_rst_n, w_out_code |-> (o_position < MAX_CODES))

    `IPWCD_ASSERT(a_ready_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    `IPWCD_ASSERT_ALWAYS(a_reset_drop, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind ir_pulse_width_code_decoder ipwcd_checker #(
    .CODE_BITS (CODE_BITS),
    .MAX_CODES (MAX_CODES)
) u_ipwcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_code_value (o_code_value),
    .o_position   (o_position)
);

`default_nettype wire
